### rtl/mfne_pkg.sv
// mfne_pkg: constants, types and codes shared by the face normal engine
// no dependencies; every other file imports this package
`default_nettype none

package mfne_pkg;

  localparam int unsigned VERTEX_DEPTH = 4096;
  localparam int unsigned COORD_BITS   = 24;
  localparam int unsigned ADDR_W       = $clog2(VERTEX_DEPTH);
  localparam int unsigned IDX_W        = 12;
  localparam int unsigned COUNT_W      = 3;
  localparam int unsigned OUT_W        = 52;

  localparam int unsigned DIFF_W  = COORD_BITS + 1;
  localparam int unsigned PROD_W  = 2 * DIFF_W;
  localparam int unsigned CROSS_W = PROD_W + 1;
  localparam int unsigned MAG_W   = CROSS_W;
  localparam int unsigned HALF_W  = (MAG_W + 1) / 2;
  localparam int unsigned SQ_W    = 2 * MAG_W;
  localparam int unsigned LEN_W   = SQ_W + 2;
  localparam int unsigned REM_W   = LEN_W + 1;
  localparam int unsigned QUO_W   = 63;
  localparam int unsigned ROOT_W  = 32;
  localparam int unsigned SREM_W  = ROOT_W + 4;
  localparam int unsigned RES_W   = ROOT_W - 1;
  localparam int unsigned STEP_W  = $clog2(QUO_W);

  localparam int unsigned NUM_AXES  = 3;
  localparam int unsigned AXIS_W    = 2;
  localparam int unsigned NUM_PARTS = 3;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_FACE = 1'b1;

  localparam logic [COUNT_W-1:0] CORNERS_TRI  = 3'd3;
  localparam logic [COUNT_W-1:0] CORNERS_QUAD = 3'd4;

  localparam logic CFG_COMPUTE   = 1'b0;
  localparam logic CFG_NORMALIZE = 1'b1;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [DIFF_W-1:0]     diff_t;
  typedef logic signed [CROSS_W-1:0]    cross_t;
  typedef logic signed [OUT_W-1:0]      normal_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } vertex_t;

  typedef enum logic [1:0] {
    KIND_ZERO,
    KIND_RAW,
    KIND_UNIT
  } kind_e;

  typedef struct packed {
    diff_t ux;
    diff_t uy;
    diff_t uz;
    diff_t vx;
    diff_t vy;
    diff_t vz;
    kind_e kind;
    logic  fmt;
    logic  last;
  } job_t;

  typedef struct packed {
    normal_t nx;
    normal_t ny;
    normal_t nz;
    logic    fmt;
    logic    degen;
    logic    last;
  } result_t;

  typedef struct packed {
    logic idle;
    logic done;
  } norm_stat_t;

  typedef enum logic [2:0] {
    NS_IDLE,
    NS_SQUARE,
    NS_DIVIDE,
    NS_ROOT,
    NS_DONE
  } norm_state_e;

endpackage

`default_nettype wire

### rtl/mfne_intf.sv
// mfne_in_if and mfne_out_if: valid/ready channels of the face normal engine
// depends on mfne_pkg
`default_nettype none

interface mfne_in_if import mfne_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic                  operation;
  logic [IDX_W-1:0]      vertex_index;
  logic signed [COORD_BITS-1:0] coord_x;
  logic signed [COORD_BITS-1:0] coord_y;
  logic signed [COORD_BITS-1:0] coord_z;
  logic [IDX_W-1:0]      corner_a;
  logic [IDX_W-1:0]      corner_b;
  logic [IDX_W-1:0]      corner_c;
  logic [IDX_W-1:0]      corner_d;
  logic [COUNT_W-1:0]    corner_count;
  logic                  last_face;

  modport source (
    output valid, operation, vertex_index, coord_x, coord_y, coord_z,
    output corner_a, corner_b, corner_c, corner_d, corner_count, last_face,
    input  ready
  );
  modport sink (
    input  valid, operation, vertex_index, coord_x, coord_y, coord_z,
    input  corner_a, corner_b, corner_c, corner_d, corner_count, last_face,
    output ready
  );
endinterface

interface mfne_out_if import mfne_pkg::*;;
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] normal_x;
  logic signed [OUT_W-1:0] normal_y;
  logic signed [OUT_W-1:0] normal_z;
  logic                    format_error;
  logic                    degenerate;
  logic                    final_res;

  modport source (
    output valid, normal_x, normal_y, normal_z, format_error, degenerate, final_res,
    input  ready
  );
  modport sink (
    input  valid, normal_x, normal_y, normal_z, format_error, degenerate, final_res,
    output ready
  );
endinterface

`default_nettype wire

### rtl/mfne_front.sv
// mfne_front: input side, vertex store with two read ports, edge vectors
// depends on mfne_pkg and mfne_in_if
`default_nettype none

module mfne_front import mfne_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  mfne_in_if.sink  in_chan,
  input  logic     compute_en_i,
  input  logic     normalize_en_i,
  input  logic     full_i,
  output logic     push_o,
  output job_t     job_o
);

  function automatic diff_t coord_sub(coord_t p, coord_t q);
    return DIFF_W'(p) - DIFF_W'(q);
  endfunction

  vertex_t mem_q [VERTEX_DEPTH];
  vertex_t rd0_q, rd1_q, a_q, b_q;
  logic    ok0_q, ok1_q;
  logic    phase_q, phase_d;
  logic    fire_q, fire_d;
  logic [IDX_W-1:0] c_idx_q, d_idx_q;
  logic    quad_q, fmt_q, last_q;
  kind_e   kind_q;

  logic    accept, face_acc, load_we, rd_en, fmt_in;
  logic [IDX_W-1:0] ra0, ra1;
  vertex_t va, vb, vc, vd, wdata;

  assign in_chan.ready = !phase_q && (!fire_q || !full_i);
  assign accept        = in_chan.valid && in_chan.ready;
  assign face_acc      = accept && (in_chan.operation == OP_FACE);
  assign load_we       = accept && (in_chan.operation == OP_LOAD)
                         && (32'(in_chan.vertex_index) < VERTEX_DEPTH);
  assign rd_en         = face_acc || phase_q;
  assign ra0           = phase_q ? c_idx_q : in_chan.corner_a;
  assign ra1           = phase_q ? d_idx_q : in_chan.corner_b;
  assign fmt_in        = (in_chan.corner_count != CORNERS_TRI)
                         && (in_chan.corner_count != CORNERS_QUAD);
  assign push_o        = fire_q && !full_i;

  always_comb begin
    wdata.x = in_chan.coord_x;
    wdata.y = in_chan.coord_y;
    wdata.z = in_chan.coord_z;
  end

  always_ff @(posedge clk_i) begin
    if (load_we) begin
      mem_q[in_chan.vertex_index[ADDR_W-1:0]] <= wdata;
    end
    if (rd_en) begin
      rd0_q <= mem_q[ra0[ADDR_W-1:0]];
      rd1_q <= mem_q[ra1[ADDR_W-1:0]];
      ok0_q <= 32'(ra0) < VERTEX_DEPTH;
      ok1_q <= 32'(ra1) < VERTEX_DEPTH;
    end
  end

  // face fields held for the second read and the push
  always_ff @(posedge clk_i) begin
    if (face_acc) begin
      c_idx_q <= in_chan.corner_c;
      d_idx_q <= in_chan.corner_d;
      quad_q  <= in_chan.corner_count == CORNERS_QUAD;
      fmt_q   <= fmt_in;
      last_q  <= in_chan.last_face;
      if (fmt_in || !compute_en_i) begin
        kind_q <= KIND_ZERO;
      end else if (normalize_en_i) begin
        kind_q <= KIND_UNIT;
      end else begin
        kind_q <= KIND_RAW;
      end
    end
    if (phase_q) begin
      a_q <= ok0_q ? rd0_q : '0;
      b_q <= ok1_q ? rd1_q : '0;
    end
  end

  always_comb begin
    phase_d = face_acc;
    if (phase_q) begin
      fire_d = 1'b1;
    end else if (push_o) begin
      fire_d = 1'b0;
    end else begin
      fire_d = fire_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= 1'b0;
      fire_q  <= 1'b0;
    end else begin
      phase_q <= phase_d;
      fire_q  <= fire_d;
    end
  end

  always_comb begin
    va = a_q;
    vb = b_q;
    vc = ok0_q ? rd0_q : '0;
    vd = ok1_q ? rd1_q : '0;
    job_o.kind = kind_q;
    job_o.fmt  = fmt_q;
    job_o.last = last_q;
    if (quad_q) begin
      job_o.ux = coord_sub(vc.x, va.x);
      job_o.uy = coord_sub(vc.y, va.y);
      job_o.uz = coord_sub(vc.z, va.z);
      job_o.vx = coord_sub(vd.x, vb.x);
      job_o.vy = coord_sub(vd.y, vb.y);
      job_o.vz = coord_sub(vd.z, vb.z);
    end else begin
      job_o.ux = coord_sub(vb.x, va.x);
      job_o.uy = coord_sub(vb.y, va.y);
      job_o.uz = coord_sub(vb.z, va.z);
      job_o.vx = coord_sub(vc.x, va.x);
      job_o.vy = coord_sub(vc.y, va.y);
      job_o.vz = coord_sub(vc.z, va.z);
    end
  end

`ifndef SYNTHESIS
  a_second_read_fires: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q |=> fire_q) else $error("second read not followed by push request");
`endif

endmodule

`default_nettype wire

### rtl/mfne_queue.sv
// mfne_queue: short queue of edge-vector jobs between front and back
// depends on mfne_pkg
`default_nettype none

module mfne_queue import mfne_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t job_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output job_t job_o
);

  job_t              slot_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_q, rd_q;
  logic [QPTR_W:0]   cnt_q;

  assign full_o  = cnt_q == (QPTR_W+1)'(QUEUE_DEPTH);
  assign valid_o = cnt_q != '0;
  assign job_o   = slot_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o) else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o) else $error("pop from empty queue");
`endif

endmodule

`default_nettype wire

### rtl/mfne_norm.sv
// mfne_norm: iterative unit normaliser, squares, long division and square root
// depends on mfne_pkg
`default_nettype none

module mfne_norm import mfne_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  cross_t     n_i [NUM_AXES],
  input  logic       take_i,
  output norm_stat_t stat_o,
  output normal_t    r_o [NUM_AXES]
);

  norm_state_e state_q, state_d;
  logic [AXIS_W-1:0] comp_q;
  logic [1:0]        part_q;
  logic [STEP_W-1:0] step_q;

  logic [MAG_W-1:0]  mag_q [NUM_AXES];
  logic              neg_q [NUM_AXES];
  logic [SQ_W-1:0]   msq_q [NUM_AXES];
  logic [LEN_W-1:0]  len_q;
  logic [REM_W-1:0]  rem_q;
  logic [QUO_W-1:0]  quo_q;
  logic [SREM_W-1:0] srem_q;
  logic [ROOT_W-1:0] root_q;
  logic [2*ROOT_W-1:0] rad_q;
  logic [RES_W-1:0]  res_q [NUM_AXES];

  logic [MAG_W-1:0]    sel_mag;
  logic [HALF_W-1:0]   m_a, m_b;
  logic [2*HALF_W-1:0] prod;
  logic [LEN_W-1:0]    ext;
  logic                div_ge, root_ge;
  logic [REM_W-1:0]    div_rem;
  logic [SREM_W-1:0]   root_t, root_trial;
  logic [ROOT_W-1:0]   root_s;
  logic [ROOT_W:0]     root_inc;
  logic                last_comp, last_part, div_end, root_end;

  assign last_comp = comp_q == AXIS_W'(NUM_AXES - 1);
  assign last_part = part_q == 2'(NUM_PARTS - 1);
  assign div_end   = step_q == STEP_W'(QUO_W - 1);
  assign root_end  = step_q == STEP_W'(ROOT_W - 1);

  assign stat_o.idle = state_q == NS_IDLE;
  assign stat_o.done = state_q == NS_DONE;

  // partial products of one square, low half and high half
  always_comb begin
    sel_mag = mag_q[comp_q];
    case (part_q)
      2'd0: begin
        m_a = sel_mag[HALF_W-1:0];
        m_b = sel_mag[HALF_W-1:0];
      end
      2'd1: begin
        m_a = HALF_W'(sel_mag >> HALF_W);
        m_b = sel_mag[HALF_W-1:0];
      end
      default: begin
        m_a = HALF_W'(sel_mag >> HALF_W);
        m_b = HALF_W'(sel_mag >> HALF_W);
      end
    endcase
    prod = m_a * m_b;
    case (part_q)
      2'd0:    ext = LEN_W'(prod);
      2'd1:    ext = LEN_W'(prod) << (HALF_W + 1);
      default: ext = LEN_W'(prod) << (2 * HALF_W);
    endcase
  end

  always_comb begin
    div_ge     = rem_q >= REM_W'(len_q);
    div_rem    = div_ge ? rem_q - REM_W'(len_q) : rem_q;
    root_t     = {srem_q[SREM_W-3:0], rad_q[2*ROOT_W-1 -: 2]};
    root_trial = SREM_W'({root_q, 2'b01});
    root_ge    = root_t >= root_trial;
    root_s     = {root_q[ROOT_W-2:0], root_ge};
    root_inc   = (ROOT_W+1)'(root_s) + 1'b1;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      NS_IDLE:   if (start_i) state_d = NS_SQUARE;
      NS_SQUARE: if (last_comp && last_part) state_d = NS_DIVIDE;
      NS_DIVIDE: if (div_end) state_d = NS_ROOT;
      NS_ROOT: begin
        if (root_end) state_d = last_comp ? NS_DONE : NS_DIVIDE;
      end
      NS_DONE:   if (take_i) state_d = NS_IDLE;
      default:   state_d = NS_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= NS_IDLE;
      comp_q  <= '0;
      part_q  <= '0;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      case (state_q)
        NS_IDLE: begin
          comp_q <= '0;
          part_q <= '0;
          step_q <= '0;
        end
        NS_SQUARE: begin
          if (last_part) begin
            part_q <= '0;
            comp_q <= last_comp ? '0 : comp_q + 1'b1;
          end else begin
            part_q <= part_q + 1'b1;
          end
        end
        NS_DIVIDE: step_q <= div_end ? '0 : step_q + 1'b1;
        NS_ROOT: begin
          step_q <= root_end ? '0 : step_q + 1'b1;
          if (root_end && !last_comp) comp_q <= comp_q + 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      NS_IDLE: begin
        if (start_i) begin
          for (int k = 0; k < NUM_AXES; k++) begin
            neg_q[k] <= n_i[k][CROSS_W-1];
            mag_q[k] <= n_i[k][CROSS_W-1] ? MAG_W'(-n_i[k]) : MAG_W'(n_i[k]);
            msq_q[k] <= '0;
          end
          len_q <= '0;
        end
      end
      NS_SQUARE: begin
        msq_q[comp_q] <= msq_q[comp_q] + ext[SQ_W-1:0];
        len_q         <= len_q + ext;
        if (last_comp && last_part) begin
          rem_q <= REM_W'(msq_q[0]);
        end
      end
      NS_DIVIDE: begin
        rem_q <= div_rem << 1;
        quo_q <= {quo_q[QUO_W-2:0], div_ge};
        if (div_end) begin
          rad_q  <= {1'b0, quo_q[QUO_W-2:0], div_ge};
          srem_q <= '0;
          root_q <= '0;
        end
      end
      NS_ROOT: begin
        srem_q <= root_ge ? root_t - root_trial : root_t;
        root_q <= root_s;
        rad_q  <= rad_q << 2;
        if (root_end) begin
          res_q[comp_q] <= root_inc[RES_W:1];
          if (!last_comp) begin
            rem_q <= REM_W'(msq_q[comp_q + 1'b1]);
          end
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    for (int k = 0; k < NUM_AXES; k++) begin
      r_o[k] = neg_q[k] ? -OUT_W'(res_q[k]) : OUT_W'(res_q[k]);
    end
  end

`ifndef SYNTHESIS
  a_start_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> state_q == NS_IDLE) else $error("normaliser started while busy");
  a_take_when_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_i |-> state_q == NS_DONE) else $error("normaliser result taken early");
`endif

endmodule

`default_nettype wire

### rtl/mfne_back.sv
// mfne_back: cross product pipeline, normaliser hand-off and output register
// depends on mfne_pkg, mfne_out_if and mfne_norm
`default_nettype none

module mfne_back import mfne_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      q_valid_i,
  input  job_t      job_i,
  output logic      pop_o,
  mfne_out_if.source out_chan
);

  logic signed [PROD_W-1:0] p_q [6];
  logic   a_v_q;
  kind_e  a_kind_q;
  logic   a_fmt_q, a_last_q;

  cross_t b_n_q [NUM_AXES];
  logic   b_v_q;
  kind_e  b_kind_q;
  logic   b_fmt_q, b_last_q, b_zero_q;

  result_t out_q;
  logic    out_v_q;
  logic    n_last_q;

  cross_t  n_d [NUM_AXES];
  normal_t r_w [NUM_AXES];
  norm_stat_t nstat;

  logic out_free, b_direct, b_take, n_start, n_take, b_adv, a_adv;

  assign out_free = !out_v_q || out_chan.ready;
  assign b_direct = (b_kind_q != KIND_UNIT) || b_zero_q;
  assign n_take   = nstat.done && out_free;
  assign b_take   = b_v_q && b_direct && nstat.idle && out_free;
  assign n_start  = b_v_q && !b_direct && nstat.idle;
  assign b_adv    = !b_v_q || b_take || n_start;
  assign a_adv    = !a_v_q || b_adv;
  assign pop_o    = q_valid_i && a_adv;

  always_comb begin
    n_d[0] = CROSS_W'(p_q[0]) - CROSS_W'(p_q[1]);
    n_d[1] = CROSS_W'(p_q[2]) - CROSS_W'(p_q[3]);
    n_d[2] = CROSS_W'(p_q[4]) - CROSS_W'(p_q[5]);
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      p_q[0]   <= $signed(job_i.uy) * $signed(job_i.vz);
      p_q[1]   <= $signed(job_i.uz) * $signed(job_i.vy);
      p_q[2]   <= $signed(job_i.uz) * $signed(job_i.vx);
      p_q[3]   <= $signed(job_i.ux) * $signed(job_i.vz);
      p_q[4]   <= $signed(job_i.ux) * $signed(job_i.vy);
      p_q[5]   <= $signed(job_i.uy) * $signed(job_i.vx);
      a_kind_q <= job_i.kind;
      a_fmt_q  <= job_i.fmt;
      a_last_q <= job_i.last;
    end
    if (b_adv && a_v_q) begin
      b_n_q    <= n_d;
      b_zero_q <= (n_d[0] == '0) && (n_d[1] == '0) && (n_d[2] == '0);
      b_kind_q <= a_kind_q;
      b_fmt_q  <= a_fmt_q;
      b_last_q <= a_last_q;
    end
    if (n_start) begin
      n_last_q <= b_last_q;
    end
    if (n_take) begin
      out_q.nx    <= r_w[0];
      out_q.ny    <= r_w[1];
      out_q.nz    <= r_w[2];
      out_q.fmt   <= 1'b0;
      out_q.degen <= 1'b0;
      out_q.last  <= n_last_q;
    end else if (b_take) begin
      if (b_kind_q == KIND_ZERO || b_zero_q) begin
        out_q.nx <= '0;
        out_q.ny <= '0;
        out_q.nz <= '0;
      end else begin
        out_q.nx <= OUT_W'(b_n_q[0]);
        out_q.ny <= OUT_W'(b_n_q[1]);
        out_q.nz <= OUT_W'(b_n_q[2]);
      end
      out_q.fmt   <= b_fmt_q;
      out_q.degen <= (b_kind_q != KIND_ZERO) && b_zero_q;
      out_q.last  <= b_last_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q   <= 1'b0;
      b_v_q   <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (a_adv) a_v_q <= q_valid_i;
      if (b_adv) b_v_q <= a_v_q;
      if (n_take || b_take) begin
        out_v_q <= 1'b1;
      end else if (out_chan.ready) begin
        out_v_q <= 1'b0;
      end
    end
  end

  mfne_norm u_norm (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (n_start),
    .n_i     (b_n_q),
    .take_i  (n_take),
    .stat_o  (nstat),
    .r_o     (r_w)
  );

  assign out_chan.valid        = out_v_q;
  assign out_chan.normal_x     = out_q.nx;
  assign out_chan.normal_y     = out_q.ny;
  assign out_chan.normal_z     = out_q.nz;
  assign out_chan.format_error = out_q.fmt;
  assign out_chan.degenerate   = out_q.degen;
  assign out_chan.final_res    = out_q.last;

endmodule

`default_nettype wire

### rtl/mesh_face_normal_engine_unit.sv
// mesh_face_normal_engine_unit: top level, configuration registers and wiring
// depends on mfne_pkg, mfne_intf, mfne_front, mfne_queue and mfne_back
//
//   channel   dir   handshake     carries
//   in_chan   in    valid/ready   vertex load or face transaction
//   out_chan  out   valid/ready   one normal per face transaction
//   cfg       in    cfg_we_i      compute_enable, normalize_enable
//
// a face reads the dual-port vertex store twice in the front (corners a and b,
// then c and d), and the front accepts nothing during the second read
// normalised faces pass through the iterative normaliser
// (9 square steps, then 63 division and 32 root steps per axis)
// the queue and output register let front and back stall on their own
// reset is asynchronous; the vertex store has no reset and no clearing pass
`default_nettype none

module mesh_face_normal_engine_unit import mfne_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  mfne_in_if.sink     in_chan,
  mfne_out_if.source  out_chan,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic        cfg_data_i
);

  logic compute_en_q, normalize_en_q;
  logic push, full, pop, q_valid;
  job_t push_job, pop_job;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      compute_en_q   <= 1'b1;
      normalize_en_q <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_COMPUTE:   compute_en_q   <= cfg_data_i;
        CFG_NORMALIZE: normalize_en_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  mfne_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_chan        (in_chan),
    .compute_en_i   (compute_en_q),
    .normalize_en_i (normalize_en_q),
    .full_i         (full),
    .push_o         (push),
    .job_o          (push_job)
  );

  mfne_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .job_o   (pop_job)
  );

  mfne_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .job_i     (pop_job),
    .pop_o     (pop),
    .out_chan  (out_chan)
  );

endmodule

`default_nettype wire

### tb/sv/tb.sv
// tb: self-checking testbench for mesh_face_normal_engine_unit
// depends on mfne_pkg, mfne_intf and the engine RTL; predicts face normals from its
// own vertex store copy or a directed row's typed result, and compares in order
`default_nettype none

module tb import mfne_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic                op;
    logic [IDX_W-1:0]    idx;
    coord_t              x, y, z;
    logic [IDX_W-1:0]    a, b, c, d;
    logic [COUNT_W-1:0]  cnt;
    logic                last;
  } mesh_txn_t;

  typedef struct {
    mesh_txn_t txn;
    bit        typed;
    result_t   res;
  } directed_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic cfg_idx_i = 1'b0;
  logic cfg_data_i = 1'b0;

  mfne_in_if  in_if ();
  mfne_out_if out_if ();

  mesh_face_normal_engine_unit i_dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_chan   (in_if),
    .out_chan  (out_if),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i)
  );

  always #6 clk_i = ~clk_i;

  coord_t  vx_store [VERTEX_DEPTH];
  coord_t  vy_store [VERTEX_DEPTH];
  coord_t  vz_store [VERTEX_DEPTH];
  bit      slot_written [VERTEX_DEPTH];
  int      written_slots [$];
  bit      compute_on = 1'b1;
  bit      normalize_on = 1'b1;
  result_t pending_normals [$];
  int      errors = 0;
  int      faces_checked = 0;
  int      degen_seen = 0;
  int      fmt_seen = 0;
  bit      quiet = 1'b0;
  bit      hold_req = 1'b0;
  bit      hold_done = 1'b0;
  int      stall_cycles = 0;

  task automatic report(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    errors++;
  endtask

  function automatic normal_t unit_axis(input longint n, input logic [255:0] len2);
    logic [255:0] m, rhs, odd, lhs;
    logic [31:0]  r, c;
    normal_t      v;
    m = (n < 0) ? -n : n;
    rhs = (m * m) << 62;
    r = '0;
    for (int b = 30; b >= 0; b--) begin
      c = r | (32'd1 << b);
      odd = {224'd0, c} * 2 - 1;
      lhs = odd * odd * len2;
      if (lhs <= rhs) r = c;
    end
    v = {20'd0, r};
    return (n < 0) ? -v : v;
  endfunction

  function automatic bit predict_normal(input mesh_txn_t t, output result_t r);
    longint p [4][3];
    longint u [3], w [3], n [3];
    logic [IDX_W-1:0] ci [4];
    logic [255:0] len2, m;
    r = '0;
    if (t.op == OP_LOAD) begin
      vx_store[t.idx] = t.x;
      vy_store[t.idx] = t.y;
      vz_store[t.idx] = t.z;
      if (!slot_written[t.idx]) written_slots.push_back(t.idx);
      slot_written[t.idx] = 1'b1;
      return 1'b0;
    end
    r.last = t.last;
    if (t.cnt != CORNERS_TRI && t.cnt != CORNERS_QUAD) begin
      r.fmt = 1'b1;
      return 1'b1;
    end
    if (!compute_on) return 1'b1;
    ci = '{t.a, t.b, t.c, t.d};
    for (int i = 0; i < 4; i++) begin
      p[i][0] = vx_store[ci[i]];
      p[i][1] = vy_store[ci[i]];
      p[i][2] = vz_store[ci[i]];
    end
    for (int k = 0; k < 3; k++) begin
      if (t.cnt == CORNERS_QUAD) begin
        u[k] = p[2][k] - p[0][k];
        w[k] = p[3][k] - p[1][k];
      end else begin
        u[k] = p[1][k] - p[0][k];
        w[k] = p[2][k] - p[0][k];
      end
    end
    n[0] = u[1] * w[2] - u[2] * w[1];
    n[1] = u[2] * w[0] - u[0] * w[2];
    n[2] = u[0] * w[1] - u[1] * w[0];
    if (n[0] == 0 && n[1] == 0 && n[2] == 0) begin
      r.degen = 1'b1;
    end else if (normalize_on) begin
      len2 = '0;
      for (int k = 0; k < 3; k++) begin
        m = (n[k] < 0) ? -n[k] : n[k];
        len2 = len2 + m * m;
      end
      r.nx = unit_axis(n[0], len2);
      r.ny = unit_axis(n[1], len2);
      r.nz = unit_axis(n[2], len2);
    end else begin
      r.nx = n[0][OUT_W-1:0];
      r.ny = n[1][OUT_W-1:0];
      r.nz = n[2][OUT_W-1:0];
    end
    return 1'b1;
  endfunction

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic offer(input mesh_txn_t t, input bit typed, input result_t typed_res);
    int      gap;
    result_t r;
    bit      has;
    gap = 0;
    if (!quiet) while ($urandom_range(0, 99) < 24) gap++;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_if.valid        <= 1'b1;
    in_if.operation    <= t.op;
    in_if.vertex_index <= t.idx;
    in_if.coord_x      <= t.x;
    in_if.coord_y      <= t.y;
    in_if.coord_z      <= t.z;
    in_if.corner_a     <= t.a;
    in_if.corner_b     <= t.b;
    in_if.corner_c     <= t.c;
    in_if.corner_d     <= t.d;
    in_if.corner_count <= t.cnt;
    in_if.last_face    <= t.last;
    do @(posedge clk_i); while (!(in_if.valid && in_if.ready));
    has = predict_normal(t, r);
    if (has) pending_normals.push_back(typed ? typed_res : r);
    @(negedge clk_i);
  endtask

  task automatic drain_and_settle();
    in_if.valid <= 1'b0;
    while (pending_normals.size() != 0) @(negedge clk_i);
    repeat (350) @(negedge clk_i);
  endtask

  task automatic write_cfg(input bit comp, input bit norm);
    cfg_we_i <= 1'b1; cfg_idx_i <= CFG_COMPUTE; cfg_data_i <= comp;
    @(negedge clk_i);
    cfg_idx_i <= CFG_NORMALIZE; cfg_data_i <= norm;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    compute_on = comp;
    normalize_on = norm;
  endtask

  function automatic mesh_txn_t random_txn();
    mesh_txn_t t;
    int        sel;
    t.op   = ($urandom_range(0, 99) < 55) ? OP_FACE : OP_LOAD;
    t.idx  = IDX_W'($urandom);
    t.x    = COORD_BITS'($urandom);
    t.y    = COORD_BITS'($urandom);
    t.z    = COORD_BITS'($urandom);
    t.cnt  = COUNT_W'($urandom);
    t.last = 1'($urandom);
    t.a = IDX_W'($urandom); t.b = IDX_W'($urandom);
    t.c = IDX_W'($urandom); t.d = IDX_W'($urandom);
    if (t.op == OP_LOAD) begin
      if ($urandom_range(0, 99) < 25) begin
        t.x = COORD_BITS'($signed($urandom_range(0, 4)) - 2);
        t.y = COORD_BITS'($signed($urandom_range(0, 4)) - 2);
        t.z = COORD_BITS'($signed($urandom_range(0, 4)) - 2);
      end
      return t;
    end
    sel = $urandom_range(0, 99);
    if (sel < 88) t.cnt = ($urandom_range(0, 1) != 0) ? CORNERS_QUAD : CORNERS_TRI;
    t.a = IDX_W'(written_slots[$urandom_range(0, written_slots.size() - 1)]);
    t.b = IDX_W'(written_slots[$urandom_range(0, written_slots.size() - 1)]);
    t.c = IDX_W'(written_slots[$urandom_range(0, written_slots.size() - 1)]);
    t.d = IDX_W'(written_slots[$urandom_range(0, written_slots.size() - 1)]);
    if ($urandom_range(0, 99) < 8) t.c = t.a;
    return t;
  endfunction

  function automatic mesh_txn_t load_txn(input int idx, input int x, input int y, input int z);
    mesh_txn_t t;
    t = '{op: OP_LOAD, idx: IDX_W'(idx),
          x: COORD_BITS'(x), y: COORD_BITS'(y), z: COORD_BITS'(z),
          a: '0, b: '0, c: '0, d: '0, cnt: '0, last: 1'b0};
    return t;
  endfunction

  function automatic mesh_txn_t face_txn(input int a, input int b, input int c, input int d,
                                         input int cnt, input bit last);
    mesh_txn_t t;
    t = '{op: OP_FACE, idx: '0, x: '0, y: '0, z: '0,
          a: IDX_W'(a), b: IDX_W'(b), c: IDX_W'(c), d: IDX_W'(d),
          cnt: COUNT_W'(cnt), last: last};
    return t;
  endfunction

  function automatic result_t typed_result(input normal_t nz, input bit fmt, input bit degen,
                                           input bit last);
    result_t r;
    r = '0;
    r.nz = nz; r.fmt = fmt; r.degen = degen; r.last = last;
    return r;
  endfunction

  // receiver side
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req && !hold_done) begin
        out_if.ready <= 1'b0;
        for (int k = 0; k < 800; k++) @(negedge clk_i);
        hold_done = 1'b1;
      end else begin
        out_if.ready <= quiet || ($urandom_range(0, 99) >= 24);
      end
    end
  end

  always @(posedge clk_i) begin
    result_t e;
    if (in_if.valid && in_if.ready || out_if.valid && out_if.ready) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= 20000) begin
      $display("watchdog: no transaction for %0d cycles", stall_cycles);
      $display("FAILED: results differ");
      $finish;
    end
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (pending_normals.size() == 0) begin
        report("result with no face waiting");
      end else begin
        e = pending_normals.pop_front();
        faces_checked++;
        if (e.degen) degen_seen++;
        if (e.fmt) fmt_seen++;
        if (out_if.normal_x !== e.nx)
          report($sformatf("normal_x %0d, want %0d", out_if.normal_x, e.nx));
        if (out_if.normal_y !== e.ny)
          report($sformatf("normal_y %0d, want %0d", out_if.normal_y, e.ny));
        if (out_if.normal_z !== e.nz)
          report($sformatf("normal_z %0d, want %0d", out_if.normal_z, e.nz));
        if (out_if.format_error !== e.fmt)
          report($sformatf("format_error %b, want %b", out_if.format_error, e.fmt));
        if (out_if.degenerate !== e.degen)
          report($sformatf("degenerate %b, want %b", out_if.degenerate, e.degen));
        if (out_if.final_res !== e.last)
          report($sformatf("final_res %b, want %b", out_if.final_res, e.last));
      end
    end
  end

  initial begin
    directed_row_t rows [$];
    result_t       none;
    bit            phase_cfg [5][2];
    none = '0;
    in_if.valid = 1'b0; in_if.operation = OP_LOAD; in_if.vertex_index = '0;
    in_if.coord_x = '0; in_if.coord_y = '0; in_if.coord_z = '0;
    in_if.corner_a = '0; in_if.corner_b = '0; in_if.corner_c = '0; in_if.corner_d = '0;
    in_if.corner_count = '0; in_if.last_face = 1'b0;

    rows.push_back('{load_txn(0, 0, 0, 0), 0, none});
    rows.push_back('{load_txn(1, 4096, 0, 0), 0, none});
    rows.push_back('{load_txn(2, 0, 4096, 0), 0, none});
    rows.push_back('{load_txn(3, 8388607, 8388607, 8388607), 0, none});
    rows.push_back('{load_txn(4, -8388608, -8388608, -8388608), 0, none});
    rows.push_back('{load_txn(4095, 8388607, -8388608, 4096), 0, none});
    rows.push_back('{load_txn(7, -8388608, 8388607, -1), 0, none});
    rows.push_back('{face_txn(0, 1, 2, 4095, CORNERS_TRI, 0), 1,
                     typed_result(normal_t'(1) <<< 30, 0, 0, 0)});
    rows.push_back('{face_txn(1, 1, 2, 0, CORNERS_TRI, 1), 1, typed_result(0, 0, 1, 1)});
    rows.push_back('{face_txn(3, 3, 3, 3, CORNERS_QUAD, 0), 1, typed_result(0, 0, 1, 0)});
    rows.push_back('{face_txn(0, 1, 2, 4095, 0, 1), 1, typed_result(0, 1, 0, 1)});
    rows.push_back('{face_txn(0, 1, 2, 4095, 7, 0), 1, typed_result(0, 1, 0, 0)});
    rows.push_back('{face_txn(0, 1, 2, 4095, 2, 0), 1, typed_result(0, 1, 0, 0)});
    rows.push_back('{face_txn(0, 1, 2, 4095, 5, 0), 1, typed_result(0, 1, 0, 0)});
    rows.push_back('{face_txn(3, 4, 4095, 7, CORNERS_TRI, 0), 0, none});
    rows.push_back('{face_txn(3, 4, 4095, 7, CORNERS_QUAD, 1), 0, none});
    rows.push_back('{face_txn(4, 3, 7, 4095, CORNERS_QUAD, 0), 0, none});
    rows.push_back('{face_txn(4095, 7, 3, 0, CORNERS_TRI, 1), 0, none});
    rows.push_back('{face_txn(0, 4095, 1, 2, CORNERS_QUAD, 0), 0, none});
    rows.push_back('{face_txn(2, 0, 1, 4, CORNERS_TRI, 0), 0, none});

    phase_cfg = '{'{1, 0}, '{0, 1}, '{1, 1}, '{0, 0}, '{1, 0}};

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (rows[i]) offer(rows[i].txn, rows[i].typed, rows[i].res);
    drain_and_settle();

    for (int ph = 0; ph < 5; ph++) begin
      write_cfg(phase_cfg[ph][0], phase_cfg[ph][1]);
      quiet = (ph == 2);
      if (ph == 1) hold_req = 1'b1;
      for (int n = 0; n < 286; n++) offer(random_txn(), 0, none);
      drain_and_settle();
    end
    quiet = 1'b0;

    $display("covered %0d faces (%0d degenerate, %0d bad corner counts) over %0d vertex slots",
             faces_checked, degen_seen, fmt_seen, written_slots.size());
    $display("with compute and normalise switched through all four settings");
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

`default_nettype wire

### mesh_face_normal_engine_unit.f
rtl/mfne_pkg.sv
rtl/mfne_intf.sv
rtl/mfne_front.sv
rtl/mfne_queue.sv
rtl/mfne_norm.sv
rtl/mfne_back.sv
rtl/mesh_face_normal_engine_unit.sv
tb/sv/tb.sv
